/* rtl/gpsh_pkg.sv */
// ----------------------------------------------------------------------------
// gpsh_pkg: shared types and constants
// Types, CORDIC arctangent table and command/status structs for the heading
// block.
// ----------------------------------------------------------------------------
package gpsh_pkg;

  localparam int CORDIC_STEPS = 23;
  localparam int STEP_W = 5;
  localparam int ANG_W = 28;           // Q16 angles, comfortably beyond +-360 deg
  localparam int VEC_W = 68;           // CORDIC vector width for east/north
  localparam int COS_W = 34;           // Q30 cosine with growth headroom
  localparam int MUL_W = 66;
  localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(90 * 65536);
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * 65536);
  localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 * 65536);
  localparam logic signed [COS_W-1:0] CORDIC_GAIN = COS_W'(652032874);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COS,
    ST_MUL,
    ST_VEC,
    ST_DONE
  } gpsh_state_t;

  typedef struct packed {
    logic load;       // capture the update and start the reduction
    logic cos_step;   // one rotation step
    logic mul;        // form east and north
    logic vec_step;   // one vectoring step
    logic round;      // round the angle into the output register
  } gpsh_cmd_t;

  typedef struct packed {
    logic emit;       // this update closes a pair
  } gpsh_sts_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    begin
      unique case (i)
        5'd0: r = 28'sd2949120;
        5'd1: r = 28'sd1740967;
        5'd2: r = 28'sd919879;
        5'd3: r = 28'sd466945;
        5'd4: r = 28'sd234379;
        5'd5: r = 28'sd117304;
        5'd6: r = 28'sd58666;
        5'd7: r = 28'sd29335;
        5'd8: r = 28'sd14668;
        5'd9: r = 28'sd7334;
        5'd10: r = 28'sd3667;
        5'd11: r = 28'sd1833;
        5'd12: r = 28'sd917;
        5'd13: r = 28'sd458;
        5'd14: r = 28'sd229;
        5'd15: r = 28'sd115;
        5'd16: r = 28'sd57;
        5'd17: r = 28'sd29;
        5'd18: r = 28'sd14;
        5'd19: r = 28'sd7;
        5'd20: r = 28'sd4;
        5'd21: r = 28'sd2;
        5'd22: r = 28'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/gps_heading_from_coordinate_pairs.sv */
// ----------------------------------------------------------------------------
// gps_heading_from_coordinate_pairs: heading from coordinate updates
// Each request on the in_ channel carries a latitude or longitude. Every
// second request closes a pair and yields one heading on the out_ channel:
// round(atan2(dlon*cos(lat), dlat)) in whole degrees, 0 north, east positive.
// A request that does not close a pair gives no result. A closing request
// runs load, 23 rotation steps for the cosine, a multiply step, 23
// vectoring steps and a rounding step, all on one shared step per cycle;
// in_tready stays low meanwhile. The heading sits in an output register; the
// block goes back to accepting requests while it waits, and stalls before
// rounding only if the previous heading is still untaken. Reset clears all
// coordinates to zero and sets the pair flag, so the first request after
// reset gives no heading.
// ----------------------------------------------------------------------------
module gps_heading_from_coordinate_pairs import gpsh_pkg::*; #(
  parameter int COORD_FRAC_BITS = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] coord_value, [31] zero
  input  logic        in_tuser,   // [0] coord_kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [8:0] heading_deg, [15:9] zero
);

  gpsh_cmd_t cmd;
  gpsh_sts_t sts;
  logic [STEP_W-1:0] step;
  logic signed [8:0] heading;

  gpsh_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .sts, .cmd, .step
  );

  gpsh_dp #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk, .rst_n,
    .coord_kind(in_tuser),
    .coord_value(in_tdata[30:0]),
    .cmd,
    .step,
    .sts,
    .heading_deg(heading)
  );

  assign out_tdata = {7'd0, heading};

endmodule

/* rtl/gpsh_ctrl.sv */
// ----------------------------------------------------------------------------
// gpsh_ctrl: sequencer
// Walks one update through load, cosine rotation, products, vectoring and
// rounding, and runs the output handshake.
// ----------------------------------------------------------------------------
module gpsh_ctrl import gpsh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  gpsh_sts_t sts,
  output gpsh_cmd_t cmd,
  output logic [STEP_W-1:0] step
);

  gpsh_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic oval_r, oval_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      oval_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign out_tvalid = oval_r;
  assign step = step_r;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    oval_nxt = oval_r && !out_tready;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          state_nxt = ST_COS;
        end
      end
      ST_COS: begin
        // pair not complete: the update only moves the state
        if (!sts.emit) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.cos_step = 1'b1;
          step_nxt = step_r + 1'b1;
          if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        step_nxt = '0;
        state_nxt = ST_VEC;
      end
      ST_VEC: begin
        cmd.vec_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!oval_r || out_tready) begin
          cmd.round = 1'b1;
          oval_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/gpsh_dp.sv */
// ----------------------------------------------------------------------------
// gpsh_dp: datapath
// Coordinate registers, shared-step CORDIC for cosine and atan2, products
// and rounding.
// ----------------------------------------------------------------------------
module gpsh_dp import gpsh_pkg::*; #(
  parameter int COORD_FRAC_BITS = 22
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              coord_kind,
  input  logic signed [30:0] coord_value,
  input  gpsh_cmd_t         cmd,
  input  logic [STEP_W-1:0] step,
  output gpsh_sts_t         sts,
  output logic signed [8:0] heading_deg
);

  localparam int SH = COORD_FRAC_BITS - 16;

  logic signed [30:0] lat_prev_r, lat_cur_r, lon_prev_r, lon_cur_r;
  logic flag_r;
  logic signed [ANG_W-1:0] a_r, a_nxt;
  logic signed [COS_W-1:0] cx_r, cy_r;
  logic neg_r, neg_nxt;
  logic signed [VEC_W-1:0] e_r, n_r;
  logic signed [ANG_W-1:0] z_r;
  logic zero_r;
  logic south_r;
  logic signed [8:0] head_r;

  // latitude reduction for the new update (combinational from inputs/state)
  logic signed [30:0] lat_new;
  logic signed [ANG_W-1:0] aq, am;

  always_comb begin
    lat_new = coord_kind ? lat_cur_r : coord_value;
    aq = ANG_W'(lat_new >>> SH);
    // aq lies well inside +-360 deg, so one fold covers the modulo
    am = aq;
    if (am >= DEG180) am = am - DEG360;
    if (am < -DEG180) am = am + DEG360;
    neg_nxt = 1'b0;
    a_nxt = am;
    if (am > DEG90) begin
      a_nxt = DEG180 - am;
      neg_nxt = 1'b1;
    end else if (am < -DEG90) begin
      a_nxt = -DEG180 - am;
      neg_nxt = 1'b1;
    end
  end

  // products: dx * cos and dy * 2^30, then floor shift by 2
  logic signed [31:0] dx, dy;
  logic signed [COS_W-1:0] cosv;
  logic signed [MUL_W-1:0] prod;
  logic signed [VEC_W-1:0] e0, n0;

  always_comb begin
    dx = 32'(lon_cur_r) - 32'(lon_prev_r);
    dy = 32'(lat_cur_r) - 32'(lat_prev_r);
    cosv = neg_r ? -cx_r : cx_r;
    prod = MUL_W'(dx) * MUL_W'(cosv);
    e0 = VEC_W'(prod >>> 2);
    n0 = VEC_W'(dy) <<< 28;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_prev_r <= '0;
      lat_cur_r <= '0;
      lon_prev_r <= '0;
      lon_cur_r <= '0;
      flag_r <= 1'b1;
    end else if (cmd.load) begin
      if (!coord_kind) begin
        lat_prev_r <= lat_cur_r;
        lat_cur_r <= coord_value;
      end else begin
        lon_prev_r <= lon_cur_r;
        lon_cur_r <= coord_value;
      end
      flag_r <= !flag_r;
    end
  end

  assign sts.emit = flag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= a_nxt;
      neg_r <= neg_nxt;
      cx_r <= CORDIC_GAIN;
      cy_r <= '0;
    end else if (cmd.cos_step) begin
      if (a_r >= 0) begin
        cx_r <= cx_r - (cy_r >>> step);
        cy_r <= cy_r + (cx_r >>> step);
        a_r <= a_r - atan_q16(step);
      end else begin
        cx_r <= cx_r + (cy_r >>> step);
        cy_r <= cy_r - (cx_r >>> step);
        a_r <= a_r + atan_q16(step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      zero_r <= (e0 == '0);
      south_r <= (n0 < 0);
      if (n0 < 0) begin
        z_r <= (e0 > 0) ? DEG180 : -DEG180;
        n_r <= -n0;
        e_r <= -e0;
      end else begin
        z_r <= '0;
        n_r <= n0;
        e_r <= e0;
      end
    end else if (cmd.vec_step) begin
      if (e_r >= 0) begin
        n_r <= n_r + (e_r >>> step);
        e_r <= e_r - (n_r >>> step);
        z_r <= z_r + atan_q16(step);
      end else begin
        n_r <= n_r - (e_r >>> step);
        e_r <= e_r + (n_r >>> step);
        z_r <= z_r - atan_q16(step);
      end
    end
  end

  // round half away from zero, clamp to +-180
  logic signed [ANG_W-1:0] zr;
  logic signed [ANG_W-1:0] zmag;
  logic signed [8:0] hv;

  always_comb begin
    zmag = (z_r >= 0) ? z_r : -z_r;
    zr = (zmag + ANG_W'(32768)) >>> 16;
    if (zr > ANG_W'(180)) zr = ANG_W'(180);
    if (zero_r) begin
      // with no east part the north sign alone decides
      hv = south_r ? 9'sd180 : 9'sd0;
    end else begin
      hv = (z_r >= 0) ? zr[8:0] : -zr[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) head_r <= hv;
  end

  assign heading_deg = head_r;

endmodule

/* dv/gps_heading_checker.sv */
// ----------------------------------------------------------------------------
// gps_heading_checker: heading predictor and result checker
// Watches the coordinate and heading channels. Each accepted request updates
// a private copy of the coordinate state; every request that closes a pair
// queues the predicted heading, and each accepted heading is compared with
// the oldest one in the queue.
// ----------------------------------------------------------------------------
module gps_heading_checker #(
  parameter int COORD_FRAC_BITS = 22
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit KIND_LAT = 1'b0;
  localparam int ROT_STEPS = 23;
  localparam longint GAIN_Q30 = 652032874;
  localparam longint Q16_90 = 90 * 65536;
  localparam longint Q16_180 = 180 * 65536;
  localparam longint Q16_360 = 360 * 65536;

  longint atan_tbl [ROT_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};

  longint lat_old, lat_new, lon_old, lon_new;
  bit     odd_update;
  logic signed [8:0] heading_q[$];

  assign pending = heading_q.size();

  function automatic longint lat_cosine(longint lat);
    longint a, x, y, t;
    bit flip;
    a = lat >>> (COORD_FRAC_BITS - 16);
    x = GAIN_Q30;
    y = 0;
    flip = 0;
    a = a % Q16_360;
    if (a >= Q16_180) a -= Q16_360;
    if (a < -Q16_180) a += Q16_360;
    // fold into [-90,90] and flip the sign of the cosine
    if (a > Q16_90) begin
      a = Q16_180 - a;
      flip = 1;
    end else if (a < -Q16_90) begin
      a = -Q16_180 - a;
      flip = 1;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a -= atan_tbl[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a += atan_tbl[i];
      end
      x = t;
    end
    return flip ? -x : x;
  endfunction

  function automatic logic signed [8:0] pair_heading(longint lat0, longint lat1,
                                                     longint lon0, longint lon1);
    longint e, n, z, t, r;
    e = ((lon1 - lon0) * lat_cosine(lat1)) >>> 2;
    n = ((lat1 - lat0) * (longint'(1) << 30)) >>> 2;
    z = 0;
    if (e == 0) return (n >= 0) ? 9'sd0 : 9'sd180;
    if (n < 0) begin
      z = (e > 0) ? Q16_180 : -Q16_180;
      n = -n;
      e = -e;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (e >= 0) begin
        t = n + (e >>> i);
        e = e - (n >>> i);
        z += atan_tbl[i];
      end else begin
        t = n - (e >>> i);
        e = e + (n >>> i);
        z -= atan_tbl[i];
      end
      n = t;
    end
    r = (z >= 0) ? ((z + 32768) >>> 16) : -((-z + 32768) >>> 16);
    if (r > 180) r = 180;
    if (r < -180) r = -180;
    return r[8:0];
  endfunction

  always @(posedge clk) begin
    logic signed [8:0] want;
    longint v;
    if (!rst_n) begin
      lat_old <= 0;
      lat_new <= 0;
      lon_old <= 0;
      lon_new <= 0;
      odd_update <= 0;
      errors <= 0;
      heading_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (heading_q.size() == 0) begin
          $display("%0t: unexpected heading %0d", $time, $signed(out_tdata[8:0]));
          errors <= errors + 1;
        end else begin
          want = heading_q.pop_front();
          if (out_tdata !== {7'd0, want}) begin
            $display("%0t: heading mismatch: expected %0d (0x%h) actual 0x%h",
                     $time, want, {7'd0, want}, out_tdata);
            errors <= errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        v = longint'($signed(in_tdata[30:0]));
        if (in_tuser == KIND_LAT) begin
          lat_old <= lat_new;
          lat_new <= v;
          if (odd_update) heading_q.push_back(pair_heading(lat_new, v, lon_old, lon_new));
        end else begin
          lon_old <= lon_new;
          lon_new <= v;
          if (odd_update) heading_q.push_back(pair_heading(lat_old, lat_new, lon_new, v));
        end
        odd_update <= !odd_update;
      end
    end
  end

endmodule

/* dv/tb_gps_heading_from_coordinate_pairs.sv */
// ----------------------------------------------------------------------------
// tb_gps_heading_from_coordinate_pairs: heading block testbench
// Drives directed corner updates and then random coordinate tracks with
// random idling on both channels, a long result hold-off and a drain pause;
// the checker predicts and compares every heading.
// ----------------------------------------------------------------------------
module tb_gps_heading_from_coordinate_pairs;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit KIND_LAT = 1'b0;
  localparam bit KIND_LON = 1'b1;
  localparam int COORD_MAX = 754974720;   // 180 degrees
  localparam int DEG1 = 4194304;
  localparam int RANDOM_UPDATES = 870;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  int          errors, pending;
  bit          calm = 0;
  bit          hold_results = 0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  gps_heading_from_coordinate_pairs uut (.*);

  gps_heading_checker chk (.*);

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    repeat (12) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      out_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // stop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_update(bit kind, int value);
    in_tvalid <= 1;
    in_tuser <= kind;
    in_tdata <= {1'b0, value[30:0]};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_pair(int lat, int lon);
    send_update(KIND_LAT, lat);
    send_update(KIND_LON, lon);
  endtask

  function automatic int rand_coord();
    return int'(longint'($urandom_range(2 * COORD_MAX)) - COORD_MAX);
  endfunction

  function automatic int clip(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < -COORD_MAX) return -COORD_MAX;
    return int'(v);
  endfunction

  initial begin
    int lat, lon;
    bit drained, held;
    drained = 0;
    held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // first update gives nothing, the second uses reset values for the rest
    send_update(KIND_LON, DEG1);
    send_update(KIND_LAT, 20 * DEG1);
    send_pair(COORD_MAX, COORD_MAX);
    send_pair(-COORD_MAX, -COORD_MAX);
    send_pair(90 * DEG1, 10);                    // cosine near zero
    send_pair(135 * DEG1, 11 * DEG1);            // folded latitude
    send_pair(-135 * DEG1, 9 * DEG1);
    send_pair(-135 * DEG1, 9 * DEG1);            // no movement
    send_pair(-100 * DEG1, 9 * DEG1);            // due north, no east
    send_pair(-120 * DEG1, 9 * DEG1);            // due south, no east
    send_pair(-130 * DEG1, 10 * DEG1);           // south-east
    send_pair(-140 * DEG1, 8 * DEG1);            // south-west
    send_update(KIND_LAT, 1);
    send_update(KIND_LAT, -1);
    send_update(KIND_LON, 12345);
    send_update(KIND_LON, -1);
    send_pair(0, 0);
    send_pair(45 * DEG1, 45 * DEG1);

    lat = 40 * DEG1;
    lon = 5 * DEG1;
    for (int k = 0; k < RANDOM_UPDATES; k++) begin
      calm = (k >= 300 && k < 400);
      if (k >= 500 && !drained) begin
        // stop offering until every heading is out
        drained = 1;
        in_tvalid <= 0;
        wait (pending == 0);
        @(posedge clk);
      end
      if (k >= 600 && !held) begin
        held = 1;
        hold_results = 1;
      end
      case ($urandom_range(9))
        0: send_update(1'($urandom_range(1)), rand_coord());
        1: send_pair(rand_coord(), rand_coord());
        2: begin
          lat = rand_coord();
          lon = rand_coord();
          send_update(KIND_LON, lon);
        end
        default: begin
          // a track: small moves, occasionally a jump
          lat = clip(longint'(lat) + $signed($urandom_range(40000)) - 20000);
          lon = clip(longint'(lon) + $signed($urandom_range(40000)) - 20000);
          if ($urandom_range(9) == 0) lon = clip(longint'(lon) + $signed($urandom_range(3 * DEG1)) - DEG1);
          send_pair(lat, lon);
          k++;
        end
      endcase
    end
    in_tvalid <= 0;
    calm = 0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
